FILE: sv/swat_pkg.sv
// shared types and codes for the selective-repeat window tracker
package swat_pkg;

    typedef enum logic [1:0] {
        ACT_SEND = 2'd0,
        ACT_RECV = 2'd1,
        ACT_ACK  = 2'd2,
        ACT_POLL = 2'd3
    } t_action;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_INVALID = 2'd2;

    localparam logic REG_WINDOW_SIZE = 1'b0;
    localparam logic REG_TIMEOUT     = 1'b1;

    localparam logic [5:0]  MAX_WINDOW    = 6'd32;
    localparam logic [5:0]  RESET_WINDOW  = 6'd8;
    localparam logic [31:0] RESET_TIMEOUT = 32'd1000;

    typedef struct packed {
        t_action     action;
        logic [31:0] seq_in;
        logic        ack_flag;
        logic [31:0] time_now;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] seq_out;
        logic [4:0]  slot;
        logic        retransmit_valid;
        logic        can_send;
        logic [31:0] retransmit_count;
        logic [31:0] duplicate_count;
        logic [31:0] out_of_order_count;
        logic        last;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_SEND,
        S_RX,
        S_RX_DRAIN,
        S_RX_SLIDE,
        S_ACK,
        S_P_LOOP,
        S_P_CHK,
        S_P_ADV,
        S_EMIT
    } t_state;

endpackage

FILE: sv/sliding_window_arq_tracker.sv
// selective-repeat arq window tracker: send, receive, ack and timer poll
// A request is taken when start is high and busy is low. An accepted send and
// a poll first run a bit-serial modulo of the sequence by the window size in
// S_MOD; a send then goes through S_SEND and S_EMIT. An out-of-window,
// out-of-order or stale receive goes through S_RX and S_EMIT. An in-order
// receive goes through S_RX, S_RX_DRAIN (once more per drained out-of-order
// mark), S_RX_SLIDE and S_EMIT. An ack goes through S_ACK and S_EMIT. A
// refused send or an ack without its flag goes straight to S_EMIT. After the
// modulo a poll visits S_P_LOOP and S_P_ADV per idle slot, adds S_P_CHK per
// pending slot and S_EMIT per timed-out slot. Each result is on o_res for one
// cycle with o_valid high and cannot be held off; the last one of a request
// has last set. r_mem is a 32-entry memory with one registered read port.
module sliding_window_arq_tracker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  swat_pkg::t_req  i_req,
    output logic            o_valid,
    output swat_pkg::t_res  o_res,
    input  logic            i_cfg_we,
    input  logic            i_cfg_idx,
    input  logic [31:0]     i_cfg_data
);

    swat_pkg::t_state r_state, n_state;
    swat_pkg::t_action r_act, n_act;
    logic [31:0] r_seq, n_seq, r_now, n_now;
    logic [5:0]  r_wsize;
    logic [31:0] r_timeout;
    logic [31:0] r_tx_next, n_tx_next, r_tx_base, n_tx_base, r_tx_pend, n_tx_pend;
    logic [31:0] r_rx_next, n_rx_next, r_rx_base, n_rx_base, r_rx_seen, n_rx_seen;
    logic [31:0] r_resend, n_resend, r_dup, n_dup, r_ooo, n_ooo;
    logic [31:0] r_div, n_div;
    logic [4:0]  r_rem, n_rem, r_cnt, n_cnt, r_idx, n_idx;
    logic [5:0]  r_i, n_i;
    logic [1:0]  r_e_status, n_e_status;
    logic [31:0] r_e_seq, n_e_seq;
    logic [4:0]  r_e_slot, n_e_slot;
    logic        r_e_rv, n_e_rv, r_e_last, n_e_last;
    logic        r_valid, n_valid;
    swat_pkg::t_res r_res, n_res;

    logic [31:0] r_mem [32];
    logic [31:0] r_vld;
    logic [31:0] r_mem_q;
    logic        r_vld_q;
    logic        wr_en;
    logic [31:0] wr_data;

    logic [5:0]  win;
    logic        room;
    logic [5:0]  mod_t;
    logic [31:0] diff, off, d, k, stamp;
    logic [5:0]  idx_inc;

    assign win  = (r_wsize == 6'd0) ? 6'd1 :
                  (r_wsize > swat_pkg::MAX_WINDOW) ? swat_pkg::MAX_WINDOW : r_wsize;
    assign room = (r_tx_next - r_tx_base) < {26'd0, win};
    assign mod_t = {r_rem, r_div[31]};
    assign stamp = r_vld_q ? r_mem_q : 32'd0;
    assign idx_inc = {1'b0, r_idx} + 6'd1;

    always_comb begin
        n_state = r_state; n_act = r_act; n_seq = r_seq; n_now = r_now;
        n_tx_next = r_tx_next; n_tx_base = r_tx_base; n_tx_pend = r_tx_pend;
        n_rx_next = r_rx_next; n_rx_base = r_rx_base; n_rx_seen = r_rx_seen;
        n_resend = r_resend; n_dup = r_dup; n_ooo = r_ooo;
        n_div = r_div; n_rem = r_rem; n_cnt = r_cnt; n_idx = r_idx; n_i = r_i;
        n_e_status = r_e_status; n_e_seq = r_e_seq; n_e_slot = r_e_slot;
        n_e_rv = r_e_rv; n_e_last = r_e_last;
        n_valid = 1'b0; n_res = r_res;
        wr_en = 1'b0; wr_data = r_now;
        diff = r_seq - r_tx_base;
        off = r_seq - r_rx_base;
        d = r_rx_next - r_rx_base;
        k = d - {26'd0, win} + 32'd1;
        unique case (r_state)
            swat_pkg::S_IDLE: begin
                if (start) begin
                    n_act = i_req.action; n_seq = i_req.seq_in; n_now = i_req.time_now;
                    n_e_status = swat_pkg::STAT_OK; n_e_seq = 32'd0; n_e_slot = 5'd0;
                    n_e_rv = 1'b0; n_e_last = 1'b1;
                    n_rem = 5'd0; n_cnt = 5'd31;
                    unique case (i_req.action)
                        swat_pkg::ACT_SEND: begin
                            if (room) begin
                                n_div = r_tx_next; n_state = swat_pkg::S_MOD;
                            end else begin
                                n_e_status = swat_pkg::STAT_FULL; n_state = swat_pkg::S_EMIT;
                            end
                        end
                        swat_pkg::ACT_RECV: n_state = swat_pkg::S_RX;
                        swat_pkg::ACT_ACK: begin
                            if (i_req.ack_flag) begin
                                n_state = swat_pkg::S_ACK;
                            end else begin
                                n_e_status = swat_pkg::STAT_INVALID;
                                n_state = swat_pkg::S_EMIT;
                            end
                        end
                        default: begin
                            n_div = r_tx_base; n_state = swat_pkg::S_MOD;
                        end
                    endcase
                end
            end
            swat_pkg::S_MOD: begin
                // restoring division, one quotient bit per cycle
                n_rem = (mod_t >= win) ? 5'(mod_t - win) : mod_t[4:0];
                n_div = {r_div[30:0], 1'b0};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_idx = n_rem; n_i = 6'd0;
                    n_state = (r_act == swat_pkg::ACT_SEND) ? swat_pkg::S_SEND
                                                             : swat_pkg::S_P_LOOP;
                end
            end
            swat_pkg::S_SEND: begin
                wr_en = 1'b1;
                diff = r_tx_next - r_tx_base;
                if (diff < 32'd32) n_tx_pend = r_tx_pend | (32'd1 << diff[4:0]);
                n_tx_next = r_tx_next + 32'd1;
                n_e_seq = r_tx_next; n_e_slot = r_idx;
                n_state = swat_pkg::S_EMIT;
            end
            swat_pkg::S_RX: begin
                n_state = swat_pkg::S_EMIT;
                if (r_seq == r_rx_next) begin
                    n_rx_next = r_rx_next + 32'd1;
                    n_state = swat_pkg::S_RX_DRAIN;
                end else if (r_seq > r_rx_next) begin
                    if (off < {26'd0, win}) begin
                        if (!r_rx_seen[off[4:0]]) begin
                            n_ooo = r_ooo + 32'd1;
                            n_rx_seen = r_rx_seen | (32'd1 << off[4:0]);
                        end else begin
                            n_dup = r_dup + 32'd1;
                        end
                        n_e_seq = r_rx_next - 32'd1;
                    end else begin
                        n_e_status = swat_pkg::STAT_INVALID;
                    end
                end else begin
                    n_dup = r_dup + 32'd1;
                    n_e_seq = r_rx_next - 32'd1;
                end
            end
            swat_pkg::S_RX_DRAIN: begin
                if (d < 32'd32 && r_rx_seen[d[4:0]]) begin
                    n_rx_seen = r_rx_seen & ~(32'd1 << d[4:0]);
                    n_rx_next = r_rx_next + 32'd1;
                end else begin
                    n_state = swat_pkg::S_RX_SLIDE;
                end
            end
            swat_pkg::S_RX_SLIDE: begin
                if (d >= {26'd0, win}) begin
                    n_rx_base = r_rx_base + k;
                    n_rx_seen = (k >= 32'd32) ? 32'd0 : (r_rx_seen >> k[4:0]);
                end
                n_e_seq = r_rx_next - 32'd1;
                n_state = swat_pkg::S_EMIT;
            end
            swat_pkg::S_ACK: begin
                if (r_seq >= r_tx_base) begin
                    if (diff >= 32'd31) begin
                        n_tx_pend = 32'd0;
                        n_tx_base = r_tx_base + 32'd32;
                    end else begin
                        n_tx_pend = r_tx_pend >> (diff[4:0] + 5'd1);
                        n_tx_base = r_tx_base + diff + 32'd1;
                    end
                end
                n_state = swat_pkg::S_EMIT;
            end
            swat_pkg::S_P_LOOP: begin
                if (r_i >= win) begin
                    n_e_seq = 32'd0; n_e_slot = 5'd0; n_e_rv = 1'b0; n_e_last = 1'b1;
                    n_state = swat_pkg::S_EMIT;
                end else if (r_tx_pend[r_i[4:0]]) begin
                    n_state = swat_pkg::S_P_CHK;
                end else begin
                    n_state = swat_pkg::S_P_ADV;
                end
            end
            swat_pkg::S_P_CHK: begin
                n_state = swat_pkg::S_P_ADV;
                if ((r_now - stamp) > r_timeout) begin
                    wr_en = 1'b1;
                    n_resend = r_resend + 32'd1;
                    n_e_seq = r_tx_base + {26'd0, r_i};
                    n_e_slot = r_idx; n_e_rv = 1'b1; n_e_last = 1'b0;
                    n_state = swat_pkg::S_EMIT;
                end
            end
            swat_pkg::S_P_ADV: begin
                n_i = r_i + 6'd1;
                n_idx = (idx_inc == win) ? 5'd0 : idx_inc[4:0];
                n_state = swat_pkg::S_P_LOOP;
            end
            swat_pkg::S_EMIT: begin
                n_valid = 1'b1;
                n_res.status = r_e_status;
                n_res.seq_out = r_e_seq;
                n_res.slot = r_e_slot;
                n_res.retransmit_valid = r_e_rv;
                n_res.can_send = room;
                n_res.retransmit_count = r_resend;
                n_res.duplicate_count = r_dup;
                n_res.out_of_order_count = r_ooo;
                n_res.last = r_e_last;
                n_state = r_e_last ? swat_pkg::S_IDLE : swat_pkg::S_P_ADV;
            end
            default: n_state = swat_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swat_pkg::S_IDLE;
            r_wsize <= swat_pkg::RESET_WINDOW;
            r_timeout <= swat_pkg::RESET_TIMEOUT;
            r_tx_next <= '0; r_tx_base <= '0; r_tx_pend <= '0;
            r_rx_next <= '0; r_rx_base <= '0; r_rx_seen <= '0;
            r_resend <= '0; r_dup <= '0; r_ooo <= '0;
            r_valid <= 1'b0;
            r_vld <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == swat_pkg::REG_WINDOW_SIZE) r_wsize <= i_cfg_data[5:0];
                else r_timeout <= i_cfg_data;
            end
            r_tx_next <= n_tx_next; r_tx_base <= n_tx_base; r_tx_pend <= n_tx_pend;
            r_rx_next <= n_rx_next; r_rx_base <= n_rx_base; r_rx_seen <= n_rx_seen;
            r_resend <= n_resend; r_dup <= n_dup; r_ooo <= n_ooo;
            r_valid <= n_valid;
            if (wr_en) r_vld[r_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act <= n_act; r_seq <= n_seq; r_now <= n_now;
        r_div <= n_div; r_rem <= n_rem; r_cnt <= n_cnt; r_idx <= n_idx; r_i <= n_i;
        r_e_status <= n_e_status; r_e_seq <= n_e_seq; r_e_slot <= n_e_slot;
        r_e_rv <= n_e_rv; r_e_last <= n_e_last;
        r_res <= n_res;
    end

    // slot timestamp memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_idx] <= wr_data;
        r_mem_q <= r_mem[r_idx];
        r_vld_q <= r_vld[r_idx];
    end

    assign busy    = (r_state != swat_pkg::S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_rv_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.retransmit_valid |-> !o_res.last && o_res.status == swat_pkg::STAT_OK)
        else $error("resend result marked last or not ok");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request accepted without going busy");
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.last |-> busy)
        else $error("poll left before closing result");

endmodule

FILE: sim/tb_sliding_window_arq_tracker.sv
// testbench for the selective-repeat arq window tracker
`timescale 1ns / 1ps

module tb_sliding_window_arq_tracker;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    swat_pkg::t_req i_req;
    logic           o_valid;
    swat_pkg::t_res o_res;
    logic           i_cfg_we;
    logic           i_cfg_idx;
    logic [31:0]    i_cfg_data;

    sliding_window_arq_tracker uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_valid(o_valid), .o_res(o_res),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [5:0]  win_reg;
    logic [31:0] tmo_reg;
    logic [31:0] tx_next, tx_base, tx_pend, rx_next, rx_base, rx_seen;
    logic [31:0] resend_cnt, dup_cnt, ooo_cnt;
    logic [31:0] stamp [32];

    swat_pkg::t_req  pending_reqs [$];
    swat_pkg::t_res  expected_res [$];
    int    err_cnt;
    bit    quiet;
    bit    drv_gaps;
    logic  busy_at_edge;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] eff_win();
        if (win_reg == 6'd0) return 32'd1;
        if (win_reg > swat_pkg::MAX_WINDOW) return 32'd32;
        return {26'd0, win_reg};
    endfunction

    function automatic bit has_room();
        return (tx_next - tx_base) < eff_win();
    endfunction

    function automatic void push_res(logic [1:0] st, logic [31:0] sq, logic [4:0] sl,
                                     logic rv, logic lst);
        swat_pkg::t_res r;
        r.status = st;
        r.seq_out = sq;
        r.slot = sl;
        r.retransmit_valid = rv;
        r.can_send = has_room();
        r.retransmit_count = resend_cnt;
        r.duplicate_count = dup_cnt;
        r.out_of_order_count = ooo_cnt;
        r.last = lst;
        expected_res.push_back(r);
    endfunction

    function automatic void predict_request(swat_pkg::t_req q);
        logic [31:0] w, off, sq, idx, d, k;
        logic [32:0] sh;
        w = eff_win();
        case (q.action)
            swat_pkg::ACT_SEND: begin
                if (!has_room()) begin
                    push_res(swat_pkg::STAT_FULL, 0, 0, 1'b0, 1'b1);
                end else begin
                    sq = tx_next;
                    idx = sq % w;
                    stamp[idx[4:0]] = q.time_now;
                    off = sq - tx_base;
                    if (off < 32) tx_pend[off[4:0]] = 1'b1;
                    tx_next = sq + 1;
                    push_res(swat_pkg::STAT_OK, sq, idx[4:0], 1'b0, 1'b1);
                end
            end
            swat_pkg::ACT_RECV: begin
                if (q.seq_in == rx_next) begin
                    rx_next++;
                    for (int n = 0; n < 32; n++) begin
                        off = rx_next - rx_base;
                        if (off < 32 && rx_seen[off[4:0]]) begin
                            rx_seen[off[4:0]] = 1'b0;
                            rx_next++;
                        end else begin
                            break;
                        end
                    end
                    d = rx_next - rx_base;
                    if (d >= w) begin
                        k = d - w + 1;
                        rx_base += k;
                        rx_seen = (k >= 32) ? 32'd0 : rx_seen >> k;
                    end
                end else if (q.seq_in > rx_next) begin
                    off = q.seq_in - rx_base;
                    if (off < w && off < 32) begin
                        if (!rx_seen[off[4:0]]) begin
                            ooo_cnt++;
                            rx_seen[off[4:0]] = 1'b1;
                        end else begin
                            dup_cnt++;
                        end
                    end else begin
                        push_res(swat_pkg::STAT_INVALID, 0, 0, 1'b0, 1'b1);
                        return;
                    end
                end else begin
                    dup_cnt++;
                end
                push_res(swat_pkg::STAT_OK, rx_next - 1, 0, 1'b0, 1'b1);
            end
            swat_pkg::ACT_ACK: begin
                if (!q.ack_flag) begin
                    push_res(swat_pkg::STAT_INVALID, 0, 0, 1'b0, 1'b1);
                    return;
                end
                if (q.seq_in >= tx_base) begin
                    sh = {1'b0, q.seq_in - tx_base} + 33'd1;
                    if (sh > 32) sh = 32;
                    tx_pend = (sh >= 32) ? 32'd0 : tx_pend >> sh;
                    tx_base += sh[31:0];
                end
                push_res(swat_pkg::STAT_OK, 0, 0, 1'b0, 1'b1);
            end
            default: begin
                for (int i = 0; i < w; i++) begin
                    if (tx_pend[i]) begin
                        sq = tx_base + i;
                        idx = sq % w;
                        if ((q.time_now - stamp[idx[4:0]]) > tmo_reg) begin
                            stamp[idx[4:0]] = q.time_now;
                            resend_cnt++;
                            push_res(swat_pkg::STAT_OK, sq, idx[4:0], 1'b1, 1'b0);
                        end
                    end
                end
                push_res(swat_pkg::STAT_OK, 0, 0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    // driver: one request off the queue per handshake, random gap bursts while drv_gaps is set
    int gap_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left = 0;
        end else if (start && !busy_at_edge) begin
            // previous request taken at the last rising edge
            if (gap_left == 0 && drv_gaps && $urandom_range(0, 5) == 0)
                gap_left = $urandom_range(1, 12);
            if (gap_left > 0 || pending_reqs.size() == 0) begin
                start <= 1'b0;
            end else begin
                i_req <= pending_reqs.pop_front();
                start <= 1'b1;
            end
        end else if (!start) begin
            if (gap_left > 0) gap_left--;
            else if (pending_reqs.size() > 0) begin
                i_req <= pending_reqs.pop_front();
                start <= 1'b1;
            end
        end
    end

    // handshake and result check at the rising edge
    always @(posedge i_clk) begin
        busy_at_edge = busy;
        if (i_rst_n && start && !busy) predict_request(i_req);
        if (i_rst_n && o_valid) begin
            if (expected_res.size() == 0) begin
                $display("%0t unexpected result: got %p", $time, o_res);
                err_cnt++;
            end else begin
                swat_pkg::t_res e;
                e = expected_res.pop_front();
                if (e !== o_res) begin
                    $display("%0t mismatch: expected %p actual %p", $time, e, o_res);
                    err_cnt++;
                end
            end
        end
    end

    task automatic add_req(swat_pkg::t_action a, logic [31:0] sq, logic fl,
                           logic [31:0] tn);
        swat_pkg::t_req q;
        q.action = a;
        q.seq_in = sq;
        q.ack_flag = fl;
        q.time_now = tn;
        pending_reqs.push_back(q);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || start || expected_res.size() != 0 || busy)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == swat_pkg::REG_WINDOW_SIZE) win_reg = val[5:0];
        else tmo_reg = val;
    endtask

    // mostly well-formed traffic near the current window, some noise
    task automatic random_phase(int n);
        logic [31:0] tn, sq;
        int sel;
        tn = $urandom;
        for (int i = 0; i < n; i++) begin
            tn += $urandom_range(0, 600);
            sel = $urandom_range(0, 99);
            if (sel < 30) add_req(swat_pkg::ACT_SEND, $urandom, $urandom_range(0, 1), tn);
            else if (sel < 60) begin
                sq = rx_next + $urandom_range(0, 10) - 2;
                if ($urandom_range(0, 9) == 0) sq = $urandom;
                add_req(swat_pkg::ACT_RECV, sq, $urandom_range(0, 1), tn);
                while (pending_reqs.size() != 0) @(posedge i_clk);
            end else if (sel < 80) begin
                sq = tx_base + $urandom_range(0, 6) - 1;
                if ($urandom_range(0, 9) == 0) sq = $urandom;
                add_req(swat_pkg::ACT_ACK, sq, $urandom_range(0, 7) != 0, $urandom);
                while (pending_reqs.size() != 0) @(posedge i_clk);
            end else begin
                if ($urandom_range(0, 7) == 0) tn = $urandom;
                add_req(swat_pkg::ACT_POLL, $urandom, $urandom_range(0, 1), tn);
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = swat_pkg::REG_WINDOW_SIZE;
        i_cfg_data = '0;
        err_cnt = 0;
        drv_gaps = 1'b1;
        busy_at_edge = 1'b0;
        win_reg = swat_pkg::RESET_WINDOW;
        tmo_reg = swat_pkg::RESET_TIMEOUT;
        {tx_next, tx_base, tx_pend, rx_next, rx_base, rx_seen} = '0;
        {resend_cnt, dup_cnt, ooo_cnt} = '0;
        foreach (stamp[i]) stamp[i] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        // directed: fill window, overflow, out of order, duplicates, acks, polls
        for (int i = 0; i < 9; i++) add_req(swat_pkg::ACT_SEND, 0, 0, 32'd100 * i);
        add_req(swat_pkg::ACT_RECV, 32'd2, 0, 0);
        add_req(swat_pkg::ACT_RECV, 32'd2, 0, 0);
        add_req(swat_pkg::ACT_RECV, 32'd0, 0, 0);
        add_req(swat_pkg::ACT_RECV, 32'd0, 0, 0);
        add_req(swat_pkg::ACT_RECV, 32'd1, 0, 0);
        add_req(swat_pkg::ACT_RECV, 32'hFFFF_FFFF, 1, 0);
        add_req(swat_pkg::ACT_ACK, 32'd3, 1'b0, 0);
        add_req(swat_pkg::ACT_POLL, 0, 0, 32'hFFFF_FFFF);
        add_req(swat_pkg::ACT_ACK, 32'd2, 1'b1, 0);
        add_req(swat_pkg::ACT_ACK, 32'd0, 1'b1, 0);
        add_req(swat_pkg::ACT_POLL, 0, 0, 32'd500);
        add_req(swat_pkg::ACT_ACK, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        add_req(swat_pkg::ACT_POLL, 0, 0, 32'd0);
        wait_drained();

        write_reg(swat_pkg::REG_WINDOW_SIZE, 6'd32);
        write_reg(swat_pkg::REG_TIMEOUT, 32'd0);
        random_phase(120);
        wait_drained();
        write_reg(swat_pkg::REG_WINDOW_SIZE, 6'd0);
        write_reg(swat_pkg::REG_TIMEOUT, 32'hFFFF_FFFF);
        random_phase(80);
        wait_drained();
        write_reg(swat_pkg::REG_WINDOW_SIZE, 6'd63);
        write_reg(swat_pkg::REG_TIMEOUT, 32'd300);
        random_phase(120);
        wait_drained();
        write_reg(swat_pkg::REG_WINDOW_SIZE, 6'd5);
        write_reg(swat_pkg::REG_TIMEOUT, 32'd50);
        random_phase(100);
        wait_drained();
        drv_gaps = 1'b0;
        write_reg(swat_pkg::REG_WINDOW_SIZE, 6'd17);
        random_phase(80);
        wait_drained();

        if (err_cnt == 0) begin
            $display("tb_sliding_window_arq_tracker: clean");
        end else begin
            $display("tb_sliding_window_arq_tracker: errors");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_sliding_window_arq_tracker: errors");
        $finish;
    end

endmodule

FILE: filelist.f
sv/swat_pkg.sv
sv/sliding_window_arq_tracker.sv
sim/tb_sliding_window_arq_tracker.sv
